/* rtl/core/dmxtx_pkg.sv */
// dmxtx_pkg: shared types and constants for the dmx512 frame transmitter core
// no dependencies; imported by dmxtx_ram users and the top level
package dmxtx_pkg;

    localparam int DMX_MAX_SLOTS = 512;   // default slot buffer size, start code excluded
    localparam int SLOT_W        = 10;    // slot index / count field width
    localparam int TICK_W        = 16;    // timing register width
    localparam int BYTE_W        = 8;
    localparam int BITPOS_W      = 4;
    localparam int FRAME_BITS    = 11;    // start + 8 data + 2 stop
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [SLOT_W-1:0] SLOT_COUNT_RST  = SLOT_W'(512);
    localparam logic [TICK_W-1:0] BREAK_TICKS_RST = TICK_W'(7000);
    localparam logic [TICK_W-1:0] MAB_TICKS_RST   = TICK_W'(480);
    localparam logic [TICK_W-1:0] BIT_TICKS_RST   = TICK_W'(160);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SLOT_COUNT  = 2'd0,
        REG_BREAK_TICKS = 2'd1,
        REG_MAB_TICKS   = 2'd2,
        REG_BIT_TICKS   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        cmd_t               command;
        logic [SLOT_W-1:0]  slot_index;
        logic [BYTE_W-1:0]  slot_value;
    } in_item_t;

    typedef struct packed {
        logic               tx_line;
        logic [1:0]         frame_phase;
        logic [SLOT_W-1:0]  current_slot;
    } out_item_t;

endpackage

/* rtl/core/dmxtx_ram.sv */
// dmxtx_ram: generic single write port, single read port ram with registered read
// no dependencies
module dmxtx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 513
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/dmx512_frame_transmitter_core.sv */
// dmx512_frame_transmitter_core: tick driven dmx512 frame sender, top level
// depends on dmxtx_pkg and dmxtx_ram
//
//   channel   direction  handshake                      payload
//   in        sink       in_valid / in_ready            in_data  (in_item_t)
//   out       source     out_valid / out_ready          out_data (out_item_t)
//   apb       slave      psel / penable / pready        paddr, pwdata, prdata
//
// one input transfer per clock, one result per input transfer; the state update
// is a single pass from the registered state, the result goes to an output register
// backed by a skid register, so input keeps flowing while one result waits
// after reset a clearing pass zeroes all MAX_SLOTS+1 entries of the slot ram (513 by
// default), during which in_ready stays low; apb writes are taken throughout
// rst_n is asynchronous, active low; a stall on out holds results in the skid
// register and drops in_ready only when both output stages are full
module dmx512_frame_transmitter_core
    import dmxtx_pkg::*;
#(
    parameter int MAX_SLOTS = DMX_MAX_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // item input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    // result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH  = MAX_SLOTS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [SLOT_W-1:0] MAX_SLOT_IDX = SLOT_W'(MAX_SLOTS);
    localparam logic [ADDR_W-1:0] CLR_LAST     = ADDR_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_MAB   = 2'd2,
        PH_SEND  = 2'd3
    } phase_t;

    // frame state
    phase_t              phase_reg, phase_next;
    logic                run_reg, run_next;
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [BITPOS_W-1:0] bitpos_reg, bitpos_next;

    // configuration registers
    logic [SLOT_W-1:0]   slot_count_reg;
    logic [TICK_W-1:0]   break_ticks_reg, mab_ticks_reg, bit_ticks_reg;

    // ram clearing pass
    logic                clr_busy_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    // output register and skid register
    logic                out_valid_reg, skid_valid_reg;
    out_item_t           out_data_reg, skid_data_reg;

    logic                accept;
    logic                load;
    logic [TICK_W:0]     tick_inc;
    logic [TICK_W-1:0]   eff_break, eff_mab, eff_bit;
    logic [SLOT_W-1:0]   last_slot;
    logic [SLOT_W-1:0]   ptr_inc;
    logic [BITPOS_W-1:0] bitpos_inc;
    logic                slot_wr;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata, ram_rdata;
    logic [2:0]          data_sel;
    logic                line_bit;
    out_item_t           result;
    logic                out_take;
    logic                cfg_wr;

    assign accept = in_valid && in_ready;
    assign in_ready = !clr_busy_reg && !skid_valid_reg;

    // zero lengths behave as one tick
    assign eff_break = (break_ticks_reg == '0) ? TICK_W'(1) : break_ticks_reg;
    assign eff_mab   = (mab_ticks_reg   == '0) ? TICK_W'(1) : mab_ticks_reg;
    assign eff_bit   = (bit_ticks_reg   == '0) ? TICK_W'(1) : bit_ticks_reg;

    // slot count saturates at the buffer size
    assign last_slot  = (slot_count_reg > MAX_SLOT_IDX) ? MAX_SLOT_IDX : slot_count_reg;
    assign tick_inc   = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign ptr_inc    = ptr_reg + SLOT_W'(1);
    assign bitpos_inc = bitpos_reg + BITPOS_W'(1);
    assign slot_wr    = (in_data.slot_index <= MAX_SLOT_IDX);

    // next state for the accepted item
    always_comb
    begin
        phase_next  = phase_reg;
        run_next    = run_reg;
        ptr_next    = ptr_reg;
        tick_next   = tick_reg;
        bitpos_next = bitpos_reg;
        load        = 1'b0;
        case (in_data.command)
            CMD_TICK:
            begin
                case (phase_reg)
                    PH_BREAK:
                    begin
                        tick_next = tick_inc[TICK_W-1:0];
                        // counter wrap also ends the period
                        if (tick_inc[TICK_W] || tick_inc[TICK_W-1:0] >= eff_break)
                        begin
                            phase_next = PH_MAB;
                            tick_next  = '0;
                        end
                    end
                    PH_MAB:
                    begin
                        tick_next = tick_inc[TICK_W-1:0];
                        if (tick_inc[TICK_W] || tick_inc[TICK_W-1:0] >= eff_mab)
                        begin
                            phase_next = PH_SEND;
                            ptr_next   = '0;
                            load       = 1'b1;
                        end
                    end
                    PH_SEND:
                    begin
                        tick_next = tick_inc[TICK_W-1:0];
                        if (tick_inc[TICK_W] || tick_inc[TICK_W-1:0] >= eff_bit)
                        begin
                            tick_next   = '0;
                            bitpos_next = bitpos_inc;
                            if (bitpos_inc >= BITPOS_W'(FRAME_BITS))
                            begin
                                if (ptr_inc > last_slot)
                                begin
                                    // frame done: next break or back to idle
                                    phase_next = run_reg ? PH_BREAK : PH_IDLE;
                                    ptr_next   = '0;
                                end
                                else
                                begin
                                    ptr_next = ptr_inc;
                                    load     = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_WRITE:
            begin
            end
            CMD_START:
            begin
                run_next = 1'b1;
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_BREAK;
                    ptr_next   = '0;
                    tick_next  = '0;
                end
            end
            CMD_STOP:
            begin
                run_next = 1'b0;
                // a frame in flight runs to its end, break and mark do not
                if (phase_reg == PH_BREAK || phase_reg == PH_MAB)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    ptr_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            bitpos_next = '0;
            tick_next   = '0;
        end
    end

    // slot ram: the clearing pass owns the write port until it ends; a byte is
    // fetched when loaded and held in the read register for the whole slot
    assign ram_we    = clr_busy_reg || (accept && in_data.command == CMD_WRITE && slot_wr);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : in_data.slot_index[ADDR_W-1:0];
    assign ram_wdata = clr_busy_reg ? '0 : in_data.slot_value;
    assign ram_re    = accept && load;

    dmxtx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ptr_next[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // serial bit: start bit, data lsb first, then stop bits; the data bits are
    // only needed from the tick after the load, when the read register holds them
    assign data_sel = 3'(bitpos_next - BITPOS_W'(1));

    always_comb
    begin
        if (bitpos_next == '0)
        begin
            line_bit = 1'b0;
        end
        else if (bitpos_next <= BITPOS_W'(BYTE_W))
        begin
            line_bit = ram_rdata[data_sel];
        end
        else
        begin
            line_bit = 1'b1;
        end
    end

    always_comb
    begin
        result.frame_phase  = phase_next;
        result.current_slot = (phase_next == PH_SEND) ? ptr_next : '0;
        case (phase_next)
            PH_BREAK: result.tx_line = 1'b0;
            PH_SEND:  result.tx_line = line_bit;
            default:  result.tx_line = 1'b1;
        endcase
    end

    // output side
    assign out_take  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // apb port, always ready, written in the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_SLOT_COUNT:  prdata = APB_DATA_W'(slot_count_reg);
            REG_BREAK_TICKS: prdata = APB_DATA_W'(break_ticks_reg);
            REG_MAB_TICKS:   prdata = APB_DATA_W'(mab_ticks_reg);
            REG_BIT_TICKS:   prdata = APB_DATA_W'(bit_ticks_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= SLOT_COUNT_RST;
            break_ticks_reg <= BREAK_TICKS_RST;
            mab_ticks_reg   <= MAB_TICKS_RST;
            bit_ticks_reg   <= BIT_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_SLOT_COUNT:  slot_count_reg  <= pwdata[SLOT_W-1:0];
                REG_BREAK_TICKS: break_ticks_reg <= pwdata[TICK_W-1:0];
                REG_MAB_TICKS:   mab_ticks_reg   <= pwdata[TICK_W-1:0];
                REG_BIT_TICKS:   bit_ticks_reg   <= pwdata[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == CLR_LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            run_reg    <= 1'b0;
            ptr_reg    <= '0;
            tick_reg   <= '0;
            bitpos_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            ptr_reg    <= ptr_next;
            tick_reg   <= tick_next;
            bitpos_reg <= bitpos_next;
        end
    end

    // output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

endmodule

/* tb/dmx_line_checker.sv */
// dmx_line_checker: follows the item, result and apb traffic of the dmx512 transmitter,
// predicts each result with its own copy of the frame sequencer and compares field by field
// depends on dmxtx_pkg
module dmx_line_checker
    import dmxtx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    pending
);

    typedef enum logic [1:0] {
        LINE_IDLE  = 2'd0,
        LINE_BREAK = 2'd1,
        LINE_MARK  = 2'd2,
        LINE_DATA  = 2'd3
    } line_phase_t;

    logic [BYTE_W-1:0]     slot_mem [0:DMX_MAX_SLOTS];
    line_phase_t           phase;
    logic                  running;
    logic [SLOT_W-1:0]     slot_ptr;
    logic [TICK_W-1:0]     tick_cnt;
    logic [BITPOS_W-1:0]   bit_pos;
    logic [FRAME_BITS-1:0] shifter;

    logic [SLOT_W-1:0]     cfg_slots;
    logic [TICK_W-1:0]     cfg_break;
    logic [TICK_W-1:0]     cfg_mark;
    logic [TICK_W-1:0]     cfg_bit;

    out_item_t             expected_line_q [$];
    int                    errors;

    // a programmed length of zero behaves as one tick
    function automatic logic [TICK_W-1:0] min_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    function automatic logic [SLOT_W-1:0] final_slot();
        return (cfg_slots > DMX_MAX_SLOTS) ? SLOT_W'(DMX_MAX_SLOTS) : cfg_slots;
    endfunction

    task automatic load_slot_byte();
        logic [BYTE_W-1:0] data;
        data     = (slot_ptr <= DMX_MAX_SLOTS) ? slot_mem[slot_ptr] : '0;
        shifter  = {2'b11, data, 1'b0};
        bit_pos  = '0;
        tick_cnt = '0;
    endtask

    task automatic open_break();
        phase    = LINE_BREAK;
        slot_ptr = '0;
        tick_cnt = '0;
    endtask

    task automatic clock_tick();
        case (phase)
            LINE_BREAK:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt == '0 || tick_cnt >= min_one(cfg_break))
                begin
                    phase    = LINE_MARK;
                    tick_cnt = '0;
                end
            end
            LINE_MARK:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt == '0 || tick_cnt >= min_one(cfg_mark))
                begin
                    phase    = LINE_DATA;
                    slot_ptr = '0;
                    load_slot_byte();
                end
            end
            LINE_DATA:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt == '0 || tick_cnt >= min_one(cfg_bit))
                begin
                    tick_cnt = '0;
                    bit_pos  = bit_pos + 1'b1;
                    if (bit_pos >= FRAME_BITS)
                    begin
                        slot_ptr = slot_ptr + 1'b1;
                        if (slot_ptr > final_slot())
                        begin
                            if (running)
                                open_break();
                            else
                            begin
                                phase    = LINE_IDLE;
                                slot_ptr = '0;
                            end
                        end
                        else
                            load_slot_byte();
                    end
                    else
                        shifter = {1'b1, shifter[FRAME_BITS-1:1]};
                end
            end
            default: ;
        endcase
    endtask

    task automatic advance_transmitter(input in_item_t item, output out_item_t result);
        case (item.command)
            CMD_TICK:
                clock_tick();
            CMD_WRITE:
                if (item.slot_index <= DMX_MAX_SLOTS)
                    slot_mem[item.slot_index] = item.slot_value;
            CMD_START:
            begin
                running = 1'b1;
                if (phase == LINE_IDLE)
                    open_break();
            end
            default:
            begin
                // stop: break and mark are dropped, a frame on the wire runs out
                running = 1'b0;
                if (phase == LINE_BREAK || phase == LINE_MARK)
                begin
                    phase    = LINE_IDLE;
                    tick_cnt = '0;
                    slot_ptr = '0;
                end
            end
        endcase
        result.tx_line      = (phase == LINE_BREAK) ? 1'b0 :
                              (phase == LINE_DATA)  ? shifter[0] : 1'b1;
        result.frame_phase  = phase;
        result.current_slot = (phase == LINE_DATA) ? slot_ptr : '0;
    endtask

    task automatic check_field(input string name, input logic [SLOT_W-1:0] want,
                               input logic [SLOT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t result;
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i <= DMX_MAX_SLOTS; i++)
                slot_mem[i] = '0;
            phase     = LINE_IDLE;
            running   = 1'b0;
            slot_ptr  = '0;
            tick_cnt  = '0;
            bit_pos   = '0;
            shifter   = '1;
            cfg_slots = SLOT_COUNT_RST;
            cfg_break = BREAK_TICKS_RST;
            cfg_mark  = MAB_TICKS_RST;
            cfg_bit   = BIT_TICKS_RST;
            expected_line_q.delete();
            errors    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_SLOT_COUNT:  cfg_slots = pwdata[SLOT_W-1:0];
                    REG_BREAK_TICKS: cfg_break = pwdata[TICK_W-1:0];
                    REG_MAB_TICKS:   cfg_mark  = pwdata[TICK_W-1:0];
                    REG_BIT_TICKS:   cfg_bit   = pwdata[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                advance_transmitter(in_data, result);
                expected_line_q.push_back(result);
            end
            if (out_valid && out_ready)
            begin
                if (expected_line_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: %p", out_data);
                    errors++;
                end
                else
                begin
                    want = expected_line_q.pop_front();
                    check_field("tx_line", SLOT_W'(want.tx_line), SLOT_W'(out_data.tx_line));
                    check_field("frame_phase", SLOT_W'(want.frame_phase),
                                SLOT_W'(out_data.frame_phase));
                    check_field("current_slot", want.current_slot, out_data.current_slot);
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_line_q.size();
    end

endmodule

/* tb/testbench.sv */
// testbench: top level for the dmx512 frame transmitter core, drives commands and apb
// register writes, and gives the verdict; prediction and checking sit in dmx_line_checker
// depends on dmxtx_pkg, dmx512_frame_transmitter_core and dmx_line_checker
module testbench;
    import dmxtx_pkg::*;

    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 160;
    localparam int LONG_HOLD        = 400;
    localparam int WATCHDOG_LIMIT   = 5000;   // covers the ram clearing pass and the long hold

    // register settings for the random phases: slot count, break, mark, bit length
    // zero lengths act as one tick, 700 slots saturates to the buffer size
    int phase_slots [PHASES] = '{2, 0, 1, 4, 700, 1, 3, 2};
    int phase_break [PHASES] = '{3, 0, 1, 5, 1, 1, 2, 1};
    int phase_mark  [PHASES] = '{2, 0, 1, 3, 1, 4, 2, 1};
    int phase_bit   [PHASES] = '{1, 0, 2, 1, 1, 3, 1, 1};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;

    bit quiet;          // last part of the run: no idling on either side
    bit long_hold;      // asks the receiver for one long stall
    bit sender_calm;    // no gaps on the sender for the current burst
    int idle_cycles = 0;
    int n_items, n_tick, n_write, n_start, n_stop, n_settings;

    dmx512_frame_transmitter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    dmx_line_checker line_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall bursts, runs of readiness of varying length, and one
    // long hold so the output stages fill up and the core drops in_ready
    initial
    begin
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // watchdog: ends the run when neither channel has moved a transfer for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no transfer for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // command with don't-care slot fields filled at random
    function automatic in_item_t make_item(input cmd_t cmd);
        in_item_t item;
        item.command    = cmd;
        item.slot_index = SLOT_W'($urandom_range(0, 1023));
        item.slot_value = BYTE_W'($urandom_range(0, 255));
        return item;
    endfunction

    function automatic in_item_t slot_write(input int idx, input int val);
        in_item_t item;
        item.command    = CMD_WRITE;
        item.slot_index = SLOT_W'(idx);
        item.slot_value = BYTE_W'(val);
        return item;
    endfunction

    // mostly the slots the short frames send, some anywhere, a few past the buffer
    function automatic int random_index();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(0, 8);
        if (pick < 9)
            return $urandom_range(0, DMX_MAX_SLOTS);
        return $urandom_range(0, 1023);
    endfunction

    // one input transfer, with an optional gap in front of it; valid stays high
    // afterwards so back-to-back transfers follow without a gap
    task automatic offer(input in_item_t item);
        if (!sender_calm && !quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        n_items++;
        case (item.command)
            CMD_TICK:  n_tick++;
            CMD_WRITE: n_write++;
            CMD_START: n_start++;
            default:   n_stop++;
        endcase
    endtask

    task automatic tick_run(input int count);
        repeat (count) offer(make_item(CMD_TICK));
    endtask

    // sender pause: valid drops until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, then the bus goes idle; junk above the
    // register's width must be ignored by the core
    task automatic write_reg(input reg_idx_t idx, input int value);
        logic [APB_DATA_W-1:0] keep;
        keep    = (idx == REG_SLOT_COUNT) ? 32'h0000_03FF : 32'h0000_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= ($urandom & ~keep) | (APB_DATA_W'(value) & keep);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing(input int slots, input int brk, input int mark,
                                  input int bitlen);
        write_reg(REG_SLOT_COUNT, slots);
        write_reg(REG_BREAK_TICKS, brk);
        write_reg(REG_MAB_TICKS, mark);
        write_reg(REG_BIT_TICKS, bitlen);
        n_settings++;
    endtask

    // a burst is mostly a start followed by a run of ticks with the odd slot write,
    // restart or stop mixed in; the rest is a stop with ticks, or pure noise
    task automatic random_burst();
        int kind;
        int pick;
        sender_calm = ($urandom_range(0, 3) == 0);
        kind        = $urandom_range(0, 19);
        if (kind < 17)
        begin
            offer(make_item(kind < 15 ? CMD_START : CMD_STOP));
            repeat ($urandom_range(5, 60))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    offer(make_item(CMD_TICK));
                else if (pick < 95)
                    offer(slot_write(random_index(), $urandom_range(0, 255)));
                else if (pick < 98)
                    offer(make_item(CMD_START));
                else
                    offer(make_item(CMD_STOP));
            end
        end
        else
            repeat ($urandom_range(1, 10)) offer(make_item(cmd_t'($urandom_range(0, 3))));
    endtask

    initial
    begin
        int target;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet       = 1'b0;
        long_hold   = 1'b0;
        sender_calm = 1'b0;
        n_items     = 0;
        n_tick      = 0;
        n_write     = 0;
        n_start     = 0;
        n_stop      = 0;
        n_settings  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // registers are taken during the ram clearing pass; item transfers wait
        // for in_ready. short frame: start code only, one tick per period
        program_timing(0, 1, 1, 1);

        // directed part
        offer(slot_write(DMX_MAX_SLOTS, 8'hFF));       // top of the buffer
        offer(slot_write(DMX_MAX_SLOTS + 1, 8'hA5));   // just past the buffer, dropped
        offer(slot_write(1023, 8'h5A));                // all index bits set, dropped
        offer(slot_write(1, 8'h00));
        offer(slot_write(0, 8'hC3));                   // start code for the frame below
        offer(make_item(CMD_STOP));                    // stop with nothing running
        offer(make_item(CMD_START));
        offer(make_item(CMD_START));                   // start while busy only keeps it running
        offer(make_item(CMD_STOP));                    // break dropped at once
        offer(make_item(CMD_START));
        offer(make_item(CMD_TICK));                    // break over, into the mark
        offer(make_item(CMD_STOP));                    // mark dropped at once
        offer(make_item(CMD_START));
        tick_run(2);                                   // through break and mark
        offer(make_item(CMD_STOP));                    // frame on the wire runs out
        tick_run(12);                                  // eleven bits, then idle
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                // bring the line to idle under the current fast timing
                offer(make_item(CMD_STOP));
                tick_run(100);
                wait_drained();

                // 16-bit maximum lengths, cut short by lowering each register
                // once its count has passed the new value
                program_timing(1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                offer(make_item(CMD_START));
                tick_run(150);
                wait_drained();
                write_reg(REG_BREAK_TICKS, 3);
                tick_run(150);
                wait_drained();
                write_reg(REG_MAB_TICKS, 0);
                tick_run(150);
                wait_drained();
                write_reg(REG_BIT_TICKS, 0);
                offer(make_item(CMD_STOP));
                tick_run(40);
                wait_drained();
                quiet <= 1'b1;
            end

            program_timing(phase_slots[p], phase_break[p], phase_mark[p], phase_bit[p]);
            if (p == 2)
                long_hold <= 1'b1;
            target = n_items + ITEMS_PER_PHASE;
            while (n_items < target)
                random_burst();
            wait_drained();
        end

        // let anything stray surface before the verdict
        repeat (20) @(posedge clk);

        $display("covered %0d input transfers: %0d ticks, %0d slot writes, %0d starts, %0d stops",
                 n_items, n_tick, n_write, n_start, n_stop);
        $display("across %0d register settings, zero, saturated and 16-bit maximum among them",
                 n_settings);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* dmx512_frame_transmitter_core.f */
rtl/core/dmxtx_pkg.sv
rtl/core/dmxtx_ram.sv
rtl/core/dmx512_frame_transmitter_core.sv
tb/dmx_line_checker.sv
tb/testbench.sv
